// ===== hw/rtl/sre_pkg.sv =====
// Package for the sliding RMS envelope block.
// Holds the channel word types and the register index codes; no dependencies.
package sre_pkg;

	// Input word: one sample and the record start mark.
	typedef struct packed {
		logic signed [15:0] sample;
		logic               new_record;
	} in_word_t;

	// Output word: one envelope point.
	typedef struct packed {
		logic [15:0] rms_value;
		logic [15:0] point_index;
	} out_word_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_WINDOW_LEN = 2'd0,
		REG_DECIM_STEP = 2'd1,
		REG_DC_OFFSET  = 2'd2
	} reg_index_t;

	localparam int WinLenWidth = 13;
	localparam int SqWidth     = 31;
	localparam logic [12:0] WinLenReset = 13'd512;
	localparam logic [15:0] DecimReset  = 16'd64;

endpackage

// ===== hw/rtl/sre_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module sre_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/sre_fifo.sv =====
// Two-entry job queue between the accumulator front and the root back end.
// No dependencies.
module sre_fifo #(
	parameter int WIDTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       count_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	assign full     = count_q == 2'd2;
	assign empty    = count_q == 2'd0;
	assign pop_data = slot_q[rd_q];

endmodule

// ===== hw/rtl/sre_front.sv =====
// Front part: takes samples, keeps the window ring and running sum of squares,
// and queues one job per envelope point. Depends on sre_pkg and sre_ram.
module sre_front
	import sre_pkg::*;
#(
	parameter int WINDOW_MAX = 4096,
	parameter int AW = $clog2(WINDOW_MAX),
	parameter int FW = $clog2(WINDOW_MAX + 1),
	parameter int SW = SqWidth + FW,
	parameter int JW = SW + FW + 1 + 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_word_t               in_word,
	input  logic [WinLenWidth-1:0] window_len,
	input  logic [15:0]            decim_step,
	input  logic signed [15:0]     dc_offset,
	output logic                   job_push,
	output logic [JW-1:0]          job_data,
	input  logic                   job_full
);

	typedef enum logic [2:0] {S_IDLE, S_SQ, S_RD1, S_RD2, S_WR} state_t;

	state_t                state_q;
	logic [AW-1:0]         ptr_q;
	logic [FW-1:0]         fill_q;
	logic [SW-1:0]         sum_q;
	logic [15:0]           phase_q;
	logic [15:0]           point_q;
	logic signed [15:0]    d_q;
	logic [SqWidth-1:0]    sq_q;
	logic [SqWidth-1:0]    rdata;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [FW-1:0]         w_eff;
	logic [16:0]           wl_ext;
	logic [15:0]           step;
	logic [16:0]           phase_nx;
	logic signed [16:0]    diff;
	logic signed [15:0]    d_sat;
	logic [FW-1:0]         fill_dec;
	logic [SW-1:0]         sum_nx;
	logic [FW-1:0]         fill_nx;
	logic                  emit;

	// Address of the oldest stored value for a given fill.
	function automatic logic [AW-1:0] old_addr(input logic [AW-1:0] p, input logic [FW-1:0] f);
		logic signed [FW+1:0] t;
		t = $signed((FW+2)'(p)) - $signed((FW+2)'(f));
		if (t < 0) begin
			t = t + (FW+2)'(WINDOW_MAX);
		end
		return AW'(t);
	endfunction

	// Effective window length and decimation step.
	always_comb begin
		wl_ext = 17'(window_len);
		if (wl_ext == 17'd0) begin
			w_eff = FW'(1);
		end else if (wl_ext > 17'(WINDOW_MAX)) begin
			w_eff = FW'(WINDOW_MAX);
		end else begin
			w_eff = FW'(wl_ext);
		end
		step = (decim_step == 16'd0) ? 16'd1 : decim_step;
	end

	// Offset removal with saturation.
	always_comb begin
		diff = 17'(in_word.sample) - 17'(dc_offset);
		if (diff > 17'sd32767) begin
			d_sat = 16'sh7fff;
		end else if (diff < -17'sd32768) begin
			d_sat = -16'sh8000;
		end else begin
			d_sat = 16'(diff);
		end
	end

	// Ring read address and write strobe.
	always_comb begin
		fill_dec = fill_q - FW'(1);
		rd_en    = 1'b0;
		rd_addr  = old_addr(ptr_q, fill_q);
		if (state_q == S_SQ) begin
			rd_en = fill_q >= w_eff;
		end else if (state_q == S_RD1) begin
			rd_en   = fill_dec >= w_eff;
			rd_addr = old_addr(ptr_q, fill_dec);
		end
		emit    = phase_q == 16'd0;
		wr_en   = (state_q == S_WR) && !(emit && job_full);
		sum_nx  = sum_q + SW'(sq_q);
		fill_nx = fill_q + FW'(1);
		phase_nx = 17'(phase_q) + 17'd1;
	end

	sre_ram #(
		.WIDTH(SqWidth),
		.DEPTH(WINDOW_MAX)
	) u_ring (
		.clk  (clk),
		.we   (wr_en),
		.waddr(ptr_q),
		.wdata(sq_q),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// Sequencer for one sample: square, drop up to two old values, store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ptr_q   <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
			phase_q <= '0;
			point_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_word.new_record) begin
							ptr_q   <= '0;
							fill_q  <= '0;
							sum_q   <= '0;
							phase_q <= '0;
							point_q <= '0;
						end
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					state_q <= (fill_q >= w_eff) ? S_RD1 : S_WR;
				end
				S_RD1: begin
					sum_q   <= sum_q - SW'(rdata);
					fill_q  <= fill_dec;
					state_q <= (fill_dec >= w_eff) ? S_RD2 : S_WR;
				end
				S_RD2: begin
					sum_q   <= sum_q - SW'(rdata);
					fill_q  <= fill_dec;
					state_q <= S_WR;
				end
				S_WR: begin
					if (wr_en) begin
						ptr_q   <= (32'(ptr_q) == WINDOW_MAX - 1) ? '0 : ptr_q + AW'(1);
						sum_q   <= sum_nx;
						fill_q  <= fill_nx;
						phase_q <= (phase_nx >= 17'(step)) ? 16'd0 : 16'(phase_nx);
						if (emit) begin
							point_q <= point_q + 16'd1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Sample datapath: offset-removed value, then its square.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			d_q <= d_sat;
		end
		if (state_q == S_SQ) begin
			sq_q <= SqWidth'($unsigned(32'(d_q * d_q)));
		end
	end

	assign in_stall = state_q != S_IDLE;
	assign job_push = wr_en && emit;
	assign job_data = {sum_nx, fill_nx, window_len == '0, point_q};

endmodule

// ===== hw/rtl/sre_back.sv =====
// Back part: divides the queued sum by the fill, takes the integer root,
// and holds the result word for the output channel. Depends on sre_pkg.
module sre_back
	import sre_pkg::*;
#(
	parameter int WINDOW_MAX = 4096,
	parameter int FW = $clog2(WINDOW_MAX + 1),
	parameter int SW = SqWidth + FW,
	parameter int JW = SW + FW + 1 + 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_empty,
	input  logic [JW-1:0] job_data,
	output logic          job_pop,
	output logic          out_valid,
	input  logic          out_stall,
	output out_word_t     out_word
);

	localparam int CW = $clog2(SW);

	typedef enum logic [1:0] {B_IDLE, B_DIV, B_SQRT, B_DONE} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [SW-1:0]   quo_q;
	logic [FW:0]     rem_q;
	logic [FW-1:0]   div_q;
	logic            zero_q;
	logic [15:0]     point_q;
	logic [31:0]     v_q;
	logic [31:0]     res_q;
	logic [31:0]     bit_q;
	logic            out_valid_q;
	out_word_t       out_q;
	logic [FW+1:0]   rem_sh;
	logic [31:0]     trial;
	logic            out_free;

	always_comb begin
		rem_sh   = {rem_q, quo_q[SW-1]};
		trial    = res_q + bit_q;
		out_free = !out_valid_q || !out_stall;
		job_pop  = (state_q == B_IDLE) && !job_empty;
	end

	// Restoring divide, one quotient bit a cycle, then root, one bit pair a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A taken word is dropped unless a new one replaces it below.
			if (out_valid_q && !out_stall && state_q != B_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (!job_empty) begin
						cnt_q   <= CW'(SW - 1);
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					if (cnt_q == '0) begin
						cnt_q   <= CW'(15);
						state_q <= B_SQRT;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				B_SQRT: begin
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == '0) begin
						state_q <= B_DONE;
					end
				end
				B_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Arithmetic datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				{quo_q, div_q, zero_q, point_q} <= job_data;
				rem_q <= '0;
			end
			B_DIV: begin
				if (rem_sh >= (FW+2)'(div_q)) begin
					rem_q <= (FW+1)'(rem_sh - (FW+2)'(div_q));
					quo_q <= {quo_q[SW-2:0], 1'b1};
				end else begin
					rem_q <= (FW+1)'(rem_sh);
					quo_q <= {quo_q[SW-2:0], 1'b0};
				end
				if (cnt_q == '0) begin
					res_q <= '0;
					bit_q <= 32'h4000_0000;
				end
			end
			B_SQRT: begin
				if (cnt_q == CW'(15)) begin
					if (32'(quo_q) >= bit_q) begin
						v_q   <= 32'(quo_q) - bit_q;
						res_q <= bit_q;
					end else begin
						v_q <= 32'(quo_q);
					end
				end else if (v_q >= trial) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			B_DONE: begin
				if (out_free) begin
					out_q.rms_value   <= zero_q ? 16'd0 : res_q[15:0];
					out_q.point_index <= point_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

// ===== hw/rtl/sliding_rms_envelope.sv =====
// Sliding-window RMS envelope, decimated: top level with configuration registers.
// Depends on sre_pkg, sre_front, sre_fifo and sre_back.
//
// Each sample passes through the front sequencer (accept and offset, square,
// up to two ring reads for values leaving the window, one ring write), and
// the input stalls until it is stored, longer while the job queue is full.
// Each emitted point then goes through the shared divide and root unit;
// a two-entry queue lets the front keep running while that unit works, so
// the back end stalls input only when that queue is full.
// Configuration writes are always taken (cfg_ready is held high).
module sliding_rms_envelope
	import sre_pkg::*;
#(
	parameter int WINDOW_MAX = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_word,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int FW = $clog2(WINDOW_MAX + 1);
	localparam int SW = SqWidth + FW;
	localparam int JW = SW + FW + 1 + 16;

	logic [WinLenWidth-1:0] window_len_q;
	logic [15:0]            decim_step_q;
	logic signed [15:0]     dc_offset_q;
	logic                   job_push;
	logic                   job_pop;
	logic                   job_full;
	logic                   job_empty;
	logic [JW-1:0]          push_data;
	logic [JW-1:0]          pop_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= WinLenReset;
			decim_step_q <= DecimReset;
			dc_offset_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_WINDOW_LEN: window_len_q <= cfg_data[WinLenWidth-1:0];
				REG_DECIM_STEP: decim_step_q <= cfg_data;
				REG_DC_OFFSET:  dc_offset_q  <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	sre_front #(.WINDOW_MAX(WINDOW_MAX)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.window_len(window_len_q),
		.decim_step(decim_step_q),
		.dc_offset (dc_offset_q),
		.job_push  (job_push),
		.job_data  (push_data),
		.job_full  (job_full)
	);

	sre_fifo #(.WIDTH(JW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_data(push_data),
		.full     (job_full),
		.pop      (job_pop),
		.pop_data (pop_data),
		.empty    (job_empty)
	);

	sre_back #(.WINDOW_MAX(WINDOW_MAX)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_empty(job_empty),
		.job_data (pop_data),
		.job_pop  (job_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

endmodule

// ===== hw/rtl/sre_checker.sv =====
// Port-level checks for the sliding RMS envelope top level, with its bind.
// Depends on sre_pkg.
module sre_checker
	import sre_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_word,
	input logic      cfg_ready
);

	// A stalled word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	// A root of a Q15 mean square never exceeds full scale.
	a_rms_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.rms_value <= 16'd32768)
		else $error("rms value out of range");

	// Configuration writes are never refused.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind sliding_rms_envelope sre_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_word (out_word),
	.cfg_ready(cfg_ready)
);
